// File: src/gpei_pkg.sv
// ----------------------------------------------------------------------------
// gpei_pkg
// Types and constants shared by the GPIO port with edge and level interrupts.
// ----------------------------------------------------------------------------
package gpei_pkg;

    localparam int FIELD_W  = 12;
    localparam int OFFSET_W = 16;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // Control register word addresses, taken from offset bits 14..2.
    localparam logic [12:0] REG_DIR    = 13'h000;
    localparam logic [12:0] REG_SENSE  = 13'h001;
    localparam logic [12:0] REG_BOTH   = 13'h002;
    localparam logic [12:0] REG_POL    = 13'h003;
    localparam logic [12:0] REG_ENABLE = 13'h004;
    localparam logic [12:0] REG_RAW    = 13'h005;
    localparam logic [12:0] REG_MASKED = 13'h006;
    localparam logic [12:0] REG_CLEAR  = 13'h007;

    typedef struct packed {
        logic [FIELD_W-1:0]  pin_levels;
        logic [FIELD_W-1:0]  write_data;
        logic [OFFSET_W-1:0] bus_offset;
        t_opcode             opcode;
    } t_item;

    typedef struct packed {
        logic [FIELD_W-1:0] drive_enables;
        logic [FIELD_W-1:0] drive_values;
        logic               irq_line;
        logic [FIELD_W-1:0] read_data;
    } t_result;

endpackage

// File: src/gpei_regfile.sv
// ----------------------------------------------------------------------------
// gpei_regfile
// Port state, bus decode and pin sampling. The result for the presented
// request is computed combinationally; the state updates when it is taken.
// ----------------------------------------------------------------------------
module gpei_regfile #(
    parameter int PINS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  gpei_pkg::t_item  i_item,
    output gpei_pkg::t_result o_result
);

    localparam int FW = gpei_pkg::FIELD_W;

    logic [PINS-1:0] r_latch, n_latch;
    logic [PINS-1:0] r_dir, n_dir;
    logic [PINS-1:0] r_sense, n_sense;
    logic [PINS-1:0] r_both, n_both;
    logic [PINS-1:0] r_pol, n_pol;
    logic [PINS-1:0] r_enable, n_enable;
    logic [PINS-1:0] r_edge, n_edge;
    logic [PINS-1:0] r_prev, n_prev;

    // Width adapters between the 12-bit bus fields and the pin vector.
    logic [PINS+FW-1:0] wdata_ext, pins_ext, mask_ext;
    logic [PINS-1:0]    wdata_p, pins_p, mask_p;
    logic [FW+PINS-1:0] pdata_ext, raw_ext, mstat_ext, dir_ext, sense_ext;
    logic [FW+PINS-1:0] both_ext, pol_ext, en_ext, nlatch_ext, ndir_ext;

    logic [PINS-1:0] raw_status, pin_data, rising, falling, hit;
    logic [PINS-1:0] n_raw;
    logic [FW-1:0]   rdata;
    logic            is_data, is_ctrl;
    logic [12:0]     reg_sel;

    assign wdata_ext = {{PINS{1'b0}}, i_item.write_data};
    assign pins_ext  = {{PINS{1'b0}}, i_item.pin_levels};
    assign mask_ext  = {{PINS{1'b0}}, i_item.bus_offset[13:2]};
    assign wdata_p   = wdata_ext[PINS-1:0];
    assign pins_p    = pins_ext[PINS-1:0];
    assign mask_p    = mask_ext[PINS-1:0];

    assign is_data = (i_item.bus_offset[15:14] == 2'b00);
    assign is_ctrl = i_item.bus_offset[15];
    assign reg_sel = i_item.bus_offset[14:2];

    assign raw_status = (~(r_prev ^ r_pol) & r_sense) | (r_edge & ~r_sense);
    assign pin_data   = (r_latch & r_dir) | (r_prev & ~r_dir);

    assign pdata_ext = {{FW{1'b0}}, pin_data};
    assign raw_ext   = {{FW{1'b0}}, raw_status};
    assign mstat_ext = {{FW{1'b0}}, raw_status & r_enable};
    assign dir_ext   = {{FW{1'b0}}, r_dir};
    assign sense_ext = {{FW{1'b0}}, r_sense};
    assign both_ext  = {{FW{1'b0}}, r_both};
    assign pol_ext   = {{FW{1'b0}}, r_pol};
    assign en_ext    = {{FW{1'b0}}, r_enable};

    assign rising  = pins_p & ~r_prev;
    assign falling = ~pins_p & r_prev;
    assign hit     = (r_both & (rising | falling)) |
                     (~r_both & r_pol & rising) |
                     (~r_both & ~r_pol & falling);

    always_comb begin
        rdata = '0;
        if (is_data) begin
            rdata = pdata_ext[FW-1:0] & i_item.bus_offset[13:2];
        end else if (is_ctrl) begin
            case (reg_sel)
                gpei_pkg::REG_DIR:    rdata = dir_ext[FW-1:0];
                gpei_pkg::REG_SENSE:  rdata = sense_ext[FW-1:0];
                gpei_pkg::REG_BOTH:   rdata = both_ext[FW-1:0];
                gpei_pkg::REG_POL:    rdata = pol_ext[FW-1:0];
                gpei_pkg::REG_ENABLE: rdata = en_ext[FW-1:0];
                gpei_pkg::REG_RAW:    rdata = raw_ext[FW-1:0];
                gpei_pkg::REG_MASKED: rdata = mstat_ext[FW-1:0];
                default:              rdata = '0;
            endcase
        end
    end

    always_comb begin
        n_latch  = r_latch;
        n_dir    = r_dir;
        n_sense  = r_sense;
        n_both   = r_both;
        n_pol    = r_pol;
        n_enable = r_enable;
        n_edge   = r_edge;
        n_prev   = r_prev;
        case (i_item.opcode)
            gpei_pkg::OP_WRITE: begin
                if (is_data) begin
                    n_latch = (r_latch & ~mask_p) | (wdata_p & mask_p);
                end else if (is_ctrl) begin
                    case (reg_sel)
                        gpei_pkg::REG_DIR:    n_dir    = wdata_p;
                        gpei_pkg::REG_SENSE:  n_sense  = wdata_p;
                        gpei_pkg::REG_BOTH:   n_both   = wdata_p;
                        gpei_pkg::REG_POL:    n_pol    = wdata_p;
                        gpei_pkg::REG_ENABLE: n_enable = wdata_p;
                        gpei_pkg::REG_CLEAR:  n_edge   = r_edge & ~wdata_p;
                        default:              ;
                    endcase
                end
            end
            gpei_pkg::OP_TICK: begin
                n_edge = r_edge | (hit & ~r_sense);
                n_prev = pins_p;
            end
            default: ;
        endcase
    end

    // The interrupt line reflects the state after this request.
    assign n_raw      = (~(n_prev ^ n_pol) & n_sense) | (n_edge & ~n_sense);
    assign nlatch_ext = {{FW{1'b0}}, n_latch};
    assign ndir_ext   = {{FW{1'b0}}, n_dir};

    assign o_result.read_data     = (i_item.opcode == gpei_pkg::OP_READ) ? rdata : '0;
    assign o_result.irq_line      = |(n_raw & n_enable);
    assign o_result.drive_values  = nlatch_ext[FW-1:0];
    assign o_result.drive_enables = ndir_ext[FW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch  <= '0;
            r_dir    <= '0;
            r_sense  <= '0;
            r_both   <= '0;
            r_pol    <= '0;
            r_enable <= '0;
            r_edge   <= '0;
            r_prev   <= '0;
        end else if (i_fire) begin
            r_latch  <= n_latch;
            r_dir    <= n_dir;
            r_sense  <= n_sense;
            r_both   <= n_both;
            r_pol    <= n_pol;
            r_enable <= n_enable;
            r_edge   <= n_edge;
            r_prev   <= n_prev;
        end
    end

endmodule

// File: src/gpio_port_edge_level_interrupts_core.sv
// ----------------------------------------------------------------------------
// gpio_port_edge_level_interrupts_core
// GPIO port with masked data access and edge or level interrupt sensing.
//
//   channel  direction  tuser     tdata
//   s_axis   in         opcode    bus_offset, write_data, pin_levels
//   m_axis   out        -         read_data, irq_line, drive_values, drive_enables
//
// One request per clock is sustained while m_axis is ready. A request is held
// in the input register, is decoded and applied to the port state, and its
// result lands in the output register. A stall on m_axis holds the output
// register and backs up into the input register. Reset clears the port state
// and both valid flags.
// ----------------------------------------------------------------------------
module gpio_port_edge_level_interrupts_core #(
    parameter int PINS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // bus_offset, write_data, pin_levels
    input  logic [1:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // read_data, irq_line, drive_values,
                                       // drive_enables, zero pad
);

    logic              r_in_valid;
    gpei_pkg::t_item   r_in;
    logic              r_out_valid;
    gpei_pkg::t_result r_out;
    gpei_pkg::t_result result;
    logic              advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.opcode     <= gpei_pkg::t_opcode'(s_axis_tuser);
            r_in.bus_offset <= s_axis_tdata[15:0];
            r_in.write_data <= s_axis_tdata[27:16];
            r_in.pin_levels <= s_axis_tdata[39:28];
        end
    end

    gpei_regfile #(
        .PINS(PINS)
    ) u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule
